/* hw/rtl/msort_pkg.sv */
package msort_pkg;

   localparam int VALUE_W       = 64;
   localparam int MAX_ELEMS_DEF = 64;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } msort_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_res;
      logic                      last_res;
      logic                      overflow;
   } msort_rsp_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic pop;
   } msort_ctl_type;

   // what one cell shows its neighbours
   typedef struct packed {
      logic                      valid;
      logic                      shift;
      logic signed [VALUE_W-1:0] value;
   } msort_link_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } msort_state_type;

endpackage

/* hw/rtl/msort_cell.sv */
module msort_cell (
   input  logic                                        clock,
   input  logic                                        reset,
   input  msort_pkg::msort_ctl_type                    ctl,
   input  logic signed [msort_pkg::VALUE_W-1:0]        new_value,
   input  msort_pkg::msort_link_type                   left,
   input  msort_pkg::msort_link_type                   right,
   output msort_pkg::msort_link_type                   link
);

   logic                                 valid_ff;
   logic                                 valid_in;
   logic signed [msort_pkg::VALUE_W-1:0] value_ff;
   logic signed [msort_pkg::VALUE_W-1:0] value_in;
   logic                                 shift;

   // empty cells count as larger than anything; equal values stay put
   assign shift = !valid_ff || (new_value < value_ff);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.ins && shift) begin
         if (left.shift) begin
            valid_in = left.valid;
            value_in = left.value;
         end else begin
            valid_in = 1'b1;
            value_in = new_value;
         end
      end else if (ctl.pop) begin
         valid_in = right.valid;
         value_in = right.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.shift = shift;
   assign link.value = value_ff;

endmodule

/* hw/rtl/merge_sorter_top.sv */
// channel | ports                       | moves
// --------+-----------------------------+-------------------------------------------
// request | req_valid/req_ready/req_data | one value word, last closes the set
// result  | rsp_valid/rsp_ready/rsp_data | one sorted word, last_res, overflow flag
//
// Each request word is inserted into a sorted row of MAX_ELEMS cells; a word
// beyond capacity is dropped and flagged. After the closing word the row drains
// from its head, one result word per cycle while the result register is free.
// req_ready is low while draining; a stalled result holds the row in place.
// Reset empties the row and clears the count and overflow flag.
module merge_sorter_top #(
   parameter int MAX_ELEMS = msort_pkg::MAX_ELEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  msort_pkg::msort_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output msort_pkg::msort_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_ELEMS + 1);

   msort_pkg::msort_state_type state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       ovf_ff, ovf_in;
   msort_pkg::msort_rsp_type   rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   msort_pkg::msort_ctl_type   ctl;
   msort_pkg::msort_link_type  cell_w [MAX_ELEMS];
   logic                       req_fire;
   logic                       out_free;

   assign req_ready = (state_ff == msort_pkg::ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      case (state_ff)
         msort_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (cnt_ff < CNT_W'(MAX_ELEMS)) begin
                  ctl.ins = 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
               end else begin
                  // drop the word, remember the loss
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  state_in = msort_pkg::ST_DRAIN;
               end
            end
         end
         msort_pkg::ST_DRAIN: begin
            if (out_free) begin
               ctl.pop          = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_in.value_res = cell_w[0].value;
               rsp_in.last_res  = (cnt_ff == CNT_W'(1));
               rsp_in.overflow  = ovf_ff;
               cnt_in           = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  ovf_in   = 1'b0;
                  state_in = msort_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = msort_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msort_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      msort_pkg::msort_link_type left_w, right_w;
      if (i == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_mid
         assign left_w = cell_w[i-1];
      end
      if (i == MAX_ELEMS - 1) begin : g_tail
         assign right_w = '0;
      end else begin : g_body
         assign right_w = cell_w[i+1];
      end
      msort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_value (req_data.value),
         .left      (left_w),
         .right     (right_w),
         .link      (cell_w[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ELEMS))
      else $error("element count beyond capacity");

   a_head_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == msort_pkg::ST_DRAIN |-> cell_w[0].valid && cnt_ff != '0)
      else $error("draining an empty row");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msort_pkg::ST_LOAD && ovf_ff) |-> cnt_ff == CNT_W'(MAX_ELEMS))
      else $error("overflow flagged below capacity");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (ctl.pop && cnt_ff == CNT_W'(1)) |=>
         state_ff == msort_pkg::ST_LOAD && !cell_w[0].valid && cnt_ff == '0)
      else $error("row not empty after final word");

endmodule

/* test/merge_sorter_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the sorter, predicts the sorted words of each set
// and compares every accepted result word against the oldest prediction.
module merge_sorter_checker #(
   parameter int CAPACITY = msort_pkg::MAX_ELEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  msort_pkg::msort_req_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  msort_pkg::msort_rsp_type rsp_data,
   output int                       error_count,
   output int                       pending_words,
   output int                       sets_closed,
   output int                       overflow_sets,
   output int                       words_checked
);

   logic signed [msort_pkg::VALUE_W-1:0] kept_values [CAPACITY];
   int                                   kept_count;
   bit                                   dropped_seen;
   msort_pkg::msort_rsp_type             sorted_words [$];

   initial begin
      error_count   = 0;
      sets_closed   = 0;
      overflow_sets = 0;
      words_checked = 0;
      kept_count    = 0;
      dropped_seen  = 1'b0;
   end

   assign pending_words = sorted_words.size();

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Sort the kept values of the closing set and queue one word per value.
   task automatic close_set();
      logic signed [msort_pkg::VALUE_W-1:0] order [CAPACITY];
      logic signed [msort_pkg::VALUE_W-1:0] key;
      msort_pkg::msort_rsp_type             word;
      int                                   j;
      for (int i = 0; i < kept_count; i++) order[i] = kept_values[i];
      for (int i = 1; i < kept_count; i++) begin
         key = order[i];
         j   = i;
         while (j > 0 && order[j-1] > key) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = key;
      end
      for (int i = 0; i < kept_count; i++) begin
         word.value_res = order[i];
         word.last_res  = (i == kept_count - 1);
         word.overflow  = dropped_seen;
         sorted_words.push_back(word);
      end
      sets_closed++;
      if (dropped_seen) overflow_sets++;
      kept_count   = 0;
      dropped_seen = 1'b0;
   endtask

   task automatic absorb_word(input msort_pkg::msort_req_type word);
      if (kept_count < CAPACITY) begin
         kept_values[kept_count] = word.value;
         kept_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (word.last) close_set();
   endtask

   task automatic check_word(input msort_pkg::msort_rsp_type got);
      msort_pkg::msort_rsp_type want;
      words_checked++;
      if (sorted_words.size() == 0) begin
         report_mismatch($sformatf("result word %0d with no word expected",
                                   got.value_res));
      end else begin
         want = sorted_words.pop_front();
         if (got.value_res !== want.value_res)
            report_mismatch($sformatf("value_res %0d, expected %0d",
                                      got.value_res, want.value_res));
         if (got.last_res !== want.last_res)
            report_mismatch($sformatf("last_res %b, expected %b",
                                      got.last_res, want.last_res));
         if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      got.overflow, want.overflow));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kept_count   = 0;
         dropped_seen = 1'b0;
         sorted_words.delete();
      end else begin
         // take the request first so a prediction is queued before any compare
         if (req_valid && req_ready) absorb_word(req_data);
         if (rsp_valid && rsp_ready) check_word(rsp_data);
      end
   end

endmodule

/* test/tb_merge_sorter_top.sv */
`timescale 1ns / 100ps

module tb_merge_sorter_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_WORDS = 200;
   localparam int DIR_WORDS    = 22;

   localparam logic signed [msort_pkg::VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [msort_pkg::VALUE_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_ready;
   msort_pkg::msort_req_type req_data     = '0;
   logic                     rsp_valid;
   logic                     rsp_ready    = 1'b0;
   msort_pkg::msort_rsp_type rsp_data;

   logic                     calm         = 1'b0;
   logic                     hold_request = 1'b0;
   logic                     hold_taken   = 1'b0;
   int                       hold_left    = 0;
   int                       cycle_count  = 0;
   int                       random_sent  = 0;
   int                       largest_set  = 0;

   int                       error_count;
   int                       pending_words;
   int                       sets_closed;
   int                       overflow_sets;
   int                       words_checked;

   merge_sorter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   merge_sorter_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_words (pending_words),
      .sets_closed   (sets_closed),
      .overflow_sets (overflow_sets),
      .words_checked (words_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words outstanding",
                  cycle_count, pending_words);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 31);
      end
   end

   // Leaves req_valid high after the word is taken; the next call decides.
   task automatic send_word(input logic signed [msort_pkg::VALUE_W-1:0] value,
                            input logic last);
      int idle_count;
      idle_count = 0;
      if (!calm) while ($urandom_range(0, 99) < 31) idle_count++;
      if (idle_count != 0) begin
         req_valid <= 1'b0;
         repeat (idle_count) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data.value <= value;
      req_data.last  <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   function automatic logic signed [msort_pkg::VALUE_W-1:0] pick_value();
      logic signed [msort_pkg::VALUE_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $signed(64'($urandom_range(0, 7))) - 64'sd4;   // small, forces ties
         1: begin
            case ($urandom_range(0, 3))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               2: v = '0;
               default: v = -64'sd1;
            endcase
         end
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic send_random_set(input int size);
      for (int k = 0; k < size; k++) begin
         send_word(pick_value(), k == size - 1);
         random_sent++;
      end
      if (size > largest_set) largest_set = size;
   endtask

   initial begin
      logic signed [msort_pkg::VALUE_W-1:0] dir_values [DIR_WORDS];
      int                                   set_index;
      int                                   set_size;

      // single minimum, single maximum, extremes with ties, descending, repeats
      dir_values = '{VAL_MIN,
                     VAL_MAX,
                     VAL_MAX, VAL_MIN, 64'sd0, -64'sd1, 64'sd1, VAL_MIN, VAL_MAX, -64'sd1,
                     64'sd5, 64'sd4, 64'sd3, 64'sd2, 64'sd1, 64'sd0, -64'sd1,
                     -64'sd2, -64'sd2, 64'sd7, 64'sd7, 64'sd7};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_WORDS; i++)
         send_word(dir_values[i], i == 0 || i == 1 || i == 9 || i == 16 || i == 21);
      largest_set = 8;

      set_index = 0;
      while (random_sent < RANDOM_WORDS) begin
         if (set_index == 3) begin
            // full set while the result side holds off: the row fills and stalls
            hold_request <= 1'b1;
            set_size = 64;
         end else if (set_index == 6) begin
            set_size = 67;
         end else if (set_index < 9) begin
            set_size = $urandom_range(1, 10);
         end else begin
            case ($urandom_range(0, 19))
               0:       set_size = 64;
               1:       set_size = $urandom_range(65, 70);
               default: set_size = $urandom_range(1, 10);
            endcase
         end
         if (set_size > RANDOM_WORDS - random_sent) set_size = RANDOM_WORDS - random_sent;
         calm <= (set_index == 6 || set_index == 7);
         send_random_set(set_size);
         if (set_index == 8) wait_drained();
         set_index++;
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("Sorted %0d sets (%0d with dropped words, largest %0d words), %0d words checked.",
               sets_closed, overflow_sets, largest_set, words_checked);
      $display("Random words %0d, directed words %0d, run length %0d cycles.",
               random_sent, DIR_WORDS, cycle_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/msort_pkg.sv
hw/rtl/msort_cell.sv
hw/rtl/merge_sorter_top.sv
test/merge_sorter_checker.sv
test/tb_merge_sorter_top.sv
